### src/refcounted_handle_table_assert.svh
// assertion macros for the reference counted handle table
`ifndef REFCOUNTED_HANDLE_TABLE_ASSERT_SVH
`define REFCOUNTED_HANDLE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RHT_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("handle table check failed");

// next-cycle implication, sampled on clk, off during reset
`define RHT_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("handle table check failed");

`endif

### src/rht_pkg.sv
// shared types and codes for the reference counted handle table
`default_nettype none

package rht_pkg;

    localparam int INDEX_BITS = 5;
    localparam int OUT_COUNT_BITS = 8;

    typedef enum logic [1:0]
    {
        OP_GET  = 2'd0,
        OP_DUP  = 2'd1,
        OP_PUT  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_UNUSED   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t                   op;
        logic [INDEX_BITS-1:0] index;
        logic                  flag;
    } req_ctl_t;

    typedef struct packed
    {
        logic fire;
        logic hit_any;
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/rht_cell.sv
// one slot of the table: object number, reference count and chain stage
`default_nettype none

module rht_cell
    import rht_pkg::*;
#(
    parameter int SLOT_COUNT  = 32,
    parameter int NUMBER_BITS = 16,
    parameter int COUNT_BITS  = 8,
    parameter int CELL_INDEX  = 0,
    parameter int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  var  req_ctl_t                              req_ctl,
    input  wire logic [NUMBER_BITS-1:0]                req_number,
    input  var  cell_cmd_t                             cmd,
    input  wire logic [2*SLOT_BITS+2*COUNT_BITS+1:0]   chain_in,
    output logic      [2*SLOT_BITS+2*COUNT_BITS+1:0]   chain_out
);

    localparam int CMP_BITS = (SLOT_BITS > INDEX_BITS) ? SLOT_BITS : INDEX_BITS;
    localparam logic [SLOT_BITS-1:0] MY_SLOT = SLOT_BITS'(CELL_INDEX);
    localparam logic [CMP_BITS-1:0]  MY_CMP  = CMP_BITS'(CELL_INDEX);

    typedef struct packed
    {
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_slot;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  free_seen;
        logic [SLOT_BITS-1:0]  free_slot;
        logic [COUNT_BITS-1:0] addr_count;
    } link_t;

    link_t link_in;
    link_t link_out;

    logic [NUMBER_BITS-1:0] number_reg;
    logic [NUMBER_BITS-1:0] number_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;

    logic live;
    logic at_max;
    logic match;
    logic addressed;
    logic free_first;

    assign link_in   = chain_in;
    assign chain_out = link_out;

    assign live       = (count_reg != '0);
    assign at_max     = (count_reg == '1);
    assign match      = live && (number_reg == req_number);
    assign addressed  = (CMP_BITS'(req_ctl.index) == MY_CMP);
    assign free_first = !live && !link_in.free_seen;

    always_comb
    begin
        link_out.hit        = link_in.hit | match;
        link_out.hit_slot   = link_in.hit_slot | (match ? MY_SLOT : '0);
        link_out.hit_count  = link_in.hit_count | (match ? count_reg : '0);
        link_out.free_seen  = link_in.free_seen | !live;
        link_out.free_slot  = free_first ? MY_SLOT : link_in.free_slot;
        link_out.addr_count = link_in.addr_count | (addressed ? count_reg : '0);
    end

    always_comb
    begin
        number_next = number_reg;
        count_next  = count_reg;
        if (cmd.fire)
        begin
            case (req_ctl.op)
                OP_GET:
                begin
                    if (match && !at_max)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (!cmd.hit_any && free_first)
                    begin
                        count_next  = COUNT_BITS'(1);
                        number_next = req_number;
                    end
                end
                OP_DUP:
                begin
                    if (addressed && live && !at_max)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUT:
                begin
                    if (addressed && live)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg <= number_next;
    end

endmodule

`default_nettype wire

### src/refcounted_handle_table.sv
// top level of the reference counted handle table: request stage, cell chain, result register
// flow: a transfer accepted into the request register gives its result in the result register
//   once the reply side is not stalled; the single request register takes no new transfer
//   until then, and the lookup ripples through the whole row of slot cells
// reset: all reference counts clear at once, so every slot is free;
//   stored object numbers are not reset and are read only behind a live count
`default_nettype none

module refcounted_handle_table
    import rht_pkg::*;
#(
    parameter int SLOT_COUNT  = 32,
    parameter int NUMBER_BITS = 16,
    parameter int COUNT_BITS  = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [15:0] object_number,
    input  wire logic [4:0]  slot_index,
    input  wire logic        unlinked_and_loaded,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [4:0]       result_slot,
    output logic [1:0]       status,
    output logic             was_hit,
    output logic [7:0]       new_count,
    output logic             delete_now
);

    `include "refcounted_handle_table_assert.svh"

    localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef struct packed
    {
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_slot;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  free_seen;
        logic [SLOT_BITS-1:0]  free_slot;
        logic [COUNT_BITS-1:0] addr_count;
    } chain_t;

    logic                   req_valid_reg;
    logic                   req_valid_next;
    req_ctl_t               req_ctl_reg;
    logic [NUMBER_BITS-1:0] req_number_reg;

    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [4:0]             slot_reg;
    logic [4:0]             slot_next;
    status_t                status_reg;
    status_t                status_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic [7:0]             count_reg;
    logic [7:0]             count_next;
    logic                   delete_reg;
    logic                   delete_next;

    logic                   req_accept;
    logic                   fire;
    cell_cmd_t              cmd;
    chain_t                 chain [SLOT_COUNT+1];
    chain_t                 tail;

    assign req_stall  = req_valid_reg;
    assign req_accept = req_valid && !req_stall;
    assign fire       = req_valid_reg && (!rsp_valid_reg || !rsp_stall);

    assign chain[0]    = '0;
    assign tail        = chain[SLOT_COUNT];
    assign cmd.fire    = fire;
    assign cmd.hit_any = tail.hit;

    generate
        for (genvar g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            rht_cell
            #(
                .SLOT_COUNT  (SLOT_COUNT),
                .NUMBER_BITS (NUMBER_BITS),
                .COUNT_BITS  (COUNT_BITS),
                .CELL_INDEX  (g),
                .SLOT_BITS   (SLOT_BITS)
            )
            u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .req_ctl    (req_ctl_reg),
                .req_number (req_number_reg),
                .cmd        (cmd),
                .chain_in   (chain[g]),
                .chain_out  (chain[g+1])
            );
        end
    endgenerate

    // request stage
    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_ctl_reg.op    <= op_t'(operation);
            req_ctl_reg.index <= slot_index;
            req_ctl_reg.flag  <= unlinked_and_loaded;
            req_number_reg    <= NUMBER_BITS'(object_number);
        end
    end

    // result from the end of the chain
    always_comb
    begin
        slot_next   = '0;
        status_next = ST_OK;
        hit_next    = 1'b0;
        count_next  = '0;
        delete_next = 1'b0;
        case (req_ctl_reg.op)
            OP_GET:
            begin
                if (tail.hit)
                begin
                    slot_next = 5'(tail.hit_slot);
                    hit_next  = 1'b1;
                    if (tail.hit_count == '1)
                    begin
                        status_next = ST_OVERFLOW;
                        count_next  = OUT_COUNT_BITS'(tail.hit_count);
                    end
                    else
                    begin
                        count_next = OUT_COUNT_BITS'(tail.hit_count + 1'b1);
                    end
                end
                else if (tail.free_seen)
                begin
                    slot_next  = 5'(tail.free_slot);
                    count_next = OUT_COUNT_BITS'(1);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_DUP, OP_PUT:
            begin
                slot_next = req_ctl_reg.index;
                if (tail.addr_count == '0)
                begin
                    status_next = ST_UNUSED;
                end
                else if (req_ctl_reg.op == OP_DUP)
                begin
                    if (tail.addr_count == '1)
                    begin
                        status_next = ST_OVERFLOW;
                        count_next  = OUT_COUNT_BITS'(tail.addr_count);
                    end
                    else
                    begin
                        count_next = OUT_COUNT_BITS'(tail.addr_count + 1'b1);
                    end
                end
                else
                begin
                    count_next  = OUT_COUNT_BITS'(tail.addr_count - 1'b1);
                    delete_next = req_ctl_reg.flag &&
                                  (tail.addr_count == COUNT_BITS'(1));
                end
            end
            default:
            begin
                slot_next = '0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
            count_reg  <= count_next;
            delete_reg <= delete_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result_slot = slot_reg;
    assign status      = status_reg;
    assign was_hit     = hit_reg;
    assign new_count   = count_reg;
    assign delete_now  = delete_reg;

    `RHT_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid && !req_valid_reg)
    `RHT_ASSERT_NEXT(a_accept_loads_request, req_accept, req_valid_reg && req_stall)
    `RHT_ASSERT_IMPLY(a_delete_on_last_ref, rsp_valid && delete_now,
        new_count == 8'd0 && status == ST_OK && !was_hit)
    `RHT_ASSERT_IMPLY(a_hit_only_on_get, rsp_valid && was_hit,
        status == ST_OK || status == ST_OVERFLOW)

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the reference counted handle table
`timescale 1ns / 100ps

module tb_top;
    import rht_pkg::*;

    localparam int SLOTS = 32;
    localparam logic [7:0] COUNT_MAX = 8'hFF;
    localparam int VIEW_GEN = 0;
    localparam int VIEW_DUT = 1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS = 170;

    typedef struct packed
    {
        op_t         op;
        logic [15:0] number;
        logic [4:0]  slot;
        logic        flag;
    } request_t;

    typedef struct packed
    {
        logic [4:0] slot;
        status_t    status;
        logic       hit;
        logic [7:0] count;
        logic       del;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  operation = 2'd0;
    logic [15:0] object_number = 16'd0;
    logic [4:0]  slot_index = 5'd0;
    logic        unlinked_and_loaded = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [4:0]  result_slot;
    logic [1:0]  status;
    logic        was_hit;
    logic [7:0]  new_count;
    logic        delete_now;

    // two copies of the table: one steers stimulus, one predicts replies
    logic [15:0] shadow_number [2][SLOTS];
    logic [7:0]  shadow_count [2][SLOTS];

    request_t request_q[$];
    reply_t   reply_q[$];
    request_t next_req;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;
    int cycles = 0;
    int n_replies = 0;
    int n_hits = 0;
    int n_full = 0;
    int n_unused = 0;
    int n_overflow = 0;
    int n_deletes = 0;

    refcounted_handle_table dut
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .operation           (operation),
        .object_number       (object_number),
        .slot_index          (slot_index),
        .unlinked_and_loaded (unlinked_and_loaded),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .result_slot         (result_slot),
        .status              (status),
        .was_hit             (was_hit),
        .new_count           (new_count),
        .delete_now          (delete_now)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic reply_t handle_table_step(input int v, input request_t r);
        reply_t y;
        int     found;
        int     free_slot;
        int     i;
        y = '0;
        found = -1;
        free_slot = -1;
        case (r.op)
            OP_GET:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (found < 0 && shadow_count[v][i] != 0 && shadow_number[v][i] == r.number)
                        found = i;
                    if (free_slot < 0 && shadow_count[v][i] == 0)
                        free_slot = i;
                end
                if (found >= 0)
                begin
                    y.slot = found[4:0];
                    y.hit = 1'b1;
                    if (shadow_count[v][found] == COUNT_MAX)
                        y.status = ST_OVERFLOW;
                    else
                    begin
                        shadow_count[v][found] = shadow_count[v][found] + 8'd1;
                        y.status = ST_OK;
                    end
                    y.count = shadow_count[v][found];
                end
                else if (free_slot < 0)
                    y.status = ST_FULL;
                else
                begin
                    shadow_number[v][free_slot] = r.number;
                    shadow_count[v][free_slot] = 8'd1;
                    y.slot = free_slot[4:0];
                    y.status = ST_OK;
                    y.count = 8'd1;
                end
            end
            OP_DUP, OP_PUT:
            begin
                y.slot = r.slot;
                if (shadow_count[v][r.slot] == 0)
                    y.status = ST_UNUSED;
                else if (r.op == OP_DUP)
                begin
                    if (shadow_count[v][r.slot] == COUNT_MAX)
                        y.status = ST_OVERFLOW;
                    else
                    begin
                        shadow_count[v][r.slot] = shadow_count[v][r.slot] + 8'd1;
                        y.status = ST_OK;
                    end
                    y.count = shadow_count[v][r.slot];
                end
                else
                begin
                    y.del = (shadow_count[v][r.slot] == 8'd1) && r.flag;
                    shadow_count[v][r.slot] = shadow_count[v][r.slot] - 8'd1;
                    y.status = ST_OK;
                    y.count = shadow_count[v][r.slot];
                end
            end
            default:
                y = '0;
        endcase
        return y;
    endfunction

    task automatic queue_request(input op_t op, input logic [15:0] number,
                                 input logic [4:0] slot, input logic flag);
        request_t r;
        reply_t   ignored;
        r.op = op;
        r.number = number;
        r.slot = slot;
        r.flag = flag;
        ignored = handle_table_step(VIEW_GEN, r);
        request_q.push_back(r);
    endtask

    function automatic int live_slots();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (shadow_count[VIEW_GEN][i] != 0)
                n++;
        return n;
    endfunction

    function automatic int pick_live_slot();
        int n;
        int k;
        n = live_slots();
        if (n == 0)
            return -1;
        k = $urandom_range(n - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_count[VIEW_GEN][i] != 0)
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return -1;
    endfunction

    task automatic queue_random_request();
        int          roll;
        int          s;
        logic [4:0]  target;
        logic [15:0] number;
        roll = $urandom_range(99);
        s = pick_live_slot();
        target = (s < 0 || $urandom_range(9) == 0) ? 5'($urandom) : s[4:0];
        if (roll < 35)
        begin
            if (s >= 0 && $urandom_range(1) == 1)
                number = shadow_number[VIEW_GEN][s];
            else if ($urandom_range(3) == 0)
                number = 16'($urandom_range(15));
            else
                number = 16'($urandom);
            queue_request(OP_GET, number, 5'($urandom), 1'($urandom));
        end
        else if (roll < 50)
            queue_request(OP_DUP, 16'($urandom), target, 1'($urandom));
        else if (roll < 96)
            queue_request(OP_PUT, 16'($urandom), target, 1'($urandom));
        else
            queue_request(OP_NONE, 16'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic fill_table();
        int s;
        while (live_slots() < SLOTS)
            queue_request(OP_GET, 16'($urandom), 5'd0, 1'b0);
        repeat (3) queue_request(OP_GET, 16'($urandom), 5'($urandom), 1'b1);
        s = pick_live_slot();
        queue_request(OP_GET, shadow_number[VIEW_GEN][s], 5'd0, 1'b0);
    endtask

    task automatic saturate_count(output int s);
        s = pick_live_slot();
        if (s < 0)
        begin
            queue_request(OP_GET, 16'hBEEF, 5'd0, 1'b0);
            s = pick_live_slot();
        end
        while (shadow_count[VIEW_GEN][s] != COUNT_MAX)
            queue_request(OP_DUP, 16'($urandom), s[4:0], 1'b0);
        repeat (2) queue_request(OP_DUP, 16'($urandom), s[4:0], 1'b1);
        queue_request(OP_GET, shadow_number[VIEW_GEN][s], 5'($urandom), 1'b0);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || req_valid || reply_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_failure(input string msg);
        if (failures < 10)
            $display("[%0t] %s", $realtime, msg);
        failures++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            note_failure($sformatf("%s mismatch: expected %0d, got %0d", what, want, got));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            operation <= 2'd0;
            object_number <= 16'd0;
            slot_index <= 5'd0;
            unlinked_and_loaded <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = request_q.pop_front();
                req_valid <= 1'b1;
                operation <= next_req.op;
                object_number <= next_req.number;
                slot_index <= next_req.slot;
                unlinked_and_loaded <= next_req.flag;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // reply backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: check replies first, then predict for the new request
    always @(posedge clk)
    begin
        reply_t   want;
        request_t seen;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_replies++;
                if (reply_q.size() == 0)
                    note_failure("reply transfer with nothing expected");
                else
                begin
                    want = reply_q.pop_front();
                    check_field("result_slot", result_slot, want.slot);
                    check_field("status", status, want.status);
                    check_field("was_hit", was_hit, want.hit);
                    check_field("new_count", new_count, want.count);
                    check_field("delete_now", delete_now, want.del);
                    n_hits += want.hit;
                    n_deletes += want.del;
                    n_full += (want.status == ST_FULL);
                    n_unused += (want.status == ST_UNUSED);
                    n_overflow += (want.status == ST_OVERFLOW);
                end
            end
            if (req_valid && !req_stall)
            begin
                seen.op = op_t'(operation);
                seen.number = object_number;
                seen.slot = slot_index;
                seen.flag = unlinked_and_loaded;
                reply_q.push_back(handle_table_step(VIEW_DUT, seen));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int sat_slot;
        for (int v = 0; v < 2; v++)
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_number[v][i] = 16'd0;
                shadow_count[v][i] = 8'd0;
            end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: claim, hit, dup, release with and without delete, free slots
        queue_request(OP_GET, 16'h0000, 5'd0, 1'b0);
        queue_request(OP_GET, 16'hFFFF, 5'd31, 1'b1);
        queue_request(OP_GET, 16'h0000, 5'd0, 1'b0);
        queue_request(OP_DUP, 16'h0000, 5'd1, 1'b0);
        queue_request(OP_DUP, 16'hFFFF, 5'd31, 1'b1);
        queue_request(OP_PUT, 16'h0000, 5'd31, 1'b1);
        queue_request(OP_PUT, 16'h0000, 5'd0, 1'b1);
        queue_request(OP_PUT, 16'h0000, 5'd0, 1'b1);
        queue_request(OP_PUT, 16'h0000, 5'd0, 1'b1);
        queue_request(OP_PUT, 16'h0000, 5'd1, 1'b0);
        queue_request(OP_PUT, 16'h0000, 5'd1, 1'b0);
        queue_request(OP_NONE, 16'hFFFF, 5'd31, 1'b1);
        queue_request(OP_GET, 16'h5A5A, 5'd0, 1'b0);
        queue_request(OP_GET, 16'hA5A5, 5'd0, 1'b0);
        queue_request(OP_PUT, 16'h0000, 5'd0, 1'b1);
        queue_request(OP_GET, 16'h1234, 5'd0, 1'b0);
        queue_request(OP_GET, 16'hA5A5, 5'd0, 1'b0);
        queue_request(OP_DUP, 16'h0000, 5'd1, 1'b0);
        queue_request(OP_NONE, 16'h0000, 5'd0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 1)
                fill_table();
            if (ph == 3)
                saturate_count(sat_slot);
            if (ph == 6)
                while (shadow_count[VIEW_GEN][sat_slot] != 0)
                    queue_request(OP_PUT, 16'($urandom), sat_slot[4:0], 1'b1);
            repeat (PHASE_ITEMS) queue_random_request();
            // sender holds off here until every reply is back
            wait_drained();
        end

        repeat (10) @(negedge clk);
        if (reply_q.size() != 0)
            note_failure($sformatf("%0d replies never arrived", reply_q.size()));
        $display("covered %0d transfers: %0d hits, %0d table full, %0d unused slot,",
                 n_replies, n_hits, n_full, n_unused);
        $display("  %0d count overflow, %0d delete requests, %0d failures",
                 n_overflow, n_deletes, failures);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
